// ===== design/rdqir_pkg.sv =====
// Shared constants, action and status codes and the cell command type for the ring deque.
package rdqir_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int INDEX_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int LIMIT_W   = 5;
    localparam int ACTION_W  = 3;
    localparam int STATUS_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    // Item actions
    localparam logic [ACTION_W-1:0] ACT_APPEND_BACK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TAKE_FRONT   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TAKE_BACK    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ         = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WRITE        = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_SHIFT = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_FAST_REMOVE  = 3'd6;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Per-cell operations
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_APPEND = 3'd1;
    localparam logic [2:0] CELL_WRITE  = 3'd2;
    localparam logic [2:0] CELL_SHIFT  = 3'd3;
    localparam logic [2:0] CELL_FAST   = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [INDEX_W-1:0] pos;
        logic [COUNT_W-1:0] fill;
    } cell_cmd_t;

endpackage

// ===== design/ring_deque_indexed_remove.sv =====
// Ring deque top level: action decode, cell chain, fill count and result register.
// The result is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle unless a result stalls on out_ready; all cells of the chain update together.
// Input is taken whenever the result register is empty or being emptied.
// Reset (rst_n, async, low): store empty, limit 16, no result pending.
// Cell contents are not reset; only held elements are ever read.
module ring_deque_indexed_remove #(
    parameter int WORD_BITS = rdqir_pkg::WORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write_en,
    input  logic [rdqir_pkg::LIMIT_W-1:0]     cfg_write_data,
    // item in
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rdqir_pkg::ACTION_W-1:0]    action,
    input  logic [rdqir_pkg::INDEX_W-1:0]     index,
    input  logic [WORD_BITS-1:0]              value,
    // item out
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rdqir_pkg::STATUS_W-1:0]    status,
    output logic [WORD_BITS-1:0]              data_out,
    output logic [rdqir_pkg::COUNT_W-1:0]     count
);
    import rdqir_pkg::*;

    // control state
    logic [LIMIT_W-1:0]   limit_reg;
    logic [COUNT_W-1:0]   fill_reg;
    logic [COUNT_W-1:0]   fill_next;
    logic                 out_valid_reg;

    // result register (payload)
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic [COUNT_W-1:0]   count_reg;

    logic                 accept;
    logic [LIMIT_W-1:0]   limit_eff;
    logic                 is_empty;
    logic                 idx_ok;
    logic [INDEX_W-1:0]   last_pos;
    logic [INDEX_W-1:0]   rd_pos;
    cell_cmd_t            cmd;

    logic [WORD_BITS-1:0] words [DEPTH];
    logic [WORD_BITS-1:0] sel_word;
    logic [WORD_BITS-1:0] last_word;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;

    // limit saturates at the store depth
    assign limit_eff = (limit_reg > LIMIT_W'(DEPTH)) ? LIMIT_W'(DEPTH) : limit_reg;
    assign is_empty  = (fill_reg == '0);
    assign idx_ok    = (COUNT_W'(index) < fill_reg);
    assign last_pos  = INDEX_W'(fill_reg - COUNT_W'(1));

    // element i of the chain is logical position i; the back is at fill-1
    assign rd_pos    = (action == ACT_TAKE_FRONT) ? '0 :
                       (action == ACT_TAKE_BACK)  ? last_pos : index;
    assign sel_word  = words[rd_pos];
    assign last_word = words[last_pos];

    // decode: result, new fill count and the command broadcast along the chain
    always_comb
    begin
        status_next = ST_OK;
        data_next   = '0;
        fill_next   = fill_reg;
        cmd.op      = CELL_HOLD;
        cmd.pos     = index;
        cmd.fill    = fill_reg;
        unique case (action)
            ACT_APPEND_BACK:
            begin
                if (fill_reg >= COUNT_W'(limit_eff))
                    status_next = ST_FULL;
                else
                begin
                    cmd.op    = CELL_APPEND;
                    cmd.pos   = INDEX_W'(fill_reg);
                    fill_next = fill_reg + COUNT_W'(1);
                end
            end
            ACT_TAKE_FRONT:
            begin
                if (is_empty)
                    status_next = ST_INVALID;
                else
                begin
                    data_next = sel_word;
                    cmd.op    = CELL_SHIFT;
                    cmd.pos   = '0;
                    fill_next = fill_reg - COUNT_W'(1);
                end
            end
            ACT_TAKE_BACK:
            begin
                if (is_empty)
                    status_next = ST_INVALID;
                else
                begin
                    data_next = sel_word;
                    fill_next = fill_reg - COUNT_W'(1);
                end
            end
            ACT_READ:
            begin
                if (!idx_ok)
                    status_next = ST_INVALID;
                else
                    data_next = sel_word;
            end
            ACT_WRITE:
            begin
                if (!idx_ok)
                    status_next = ST_INVALID;
                else
                    cmd.op = CELL_WRITE;
            end
            ACT_REMOVE_SHIFT:
            begin
                if (!idx_ok)
                    status_next = ST_INVALID;
                else
                begin
                    data_next = sel_word;
                    cmd.op    = CELL_SHIFT;
                    fill_next = fill_reg - COUNT_W'(1);
                end
            end
            ACT_FAST_REMOVE:
            begin
                if (!idx_ok)
                    status_next = ST_INVALID;
                else
                begin
                    // back element drops into the hole
                    data_next = sel_word;
                    cmd.op    = CELL_FAST;
                    fill_next = fill_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
        if (!accept)
        begin
            cmd.op    = CELL_HOLD;
            fill_next = fill_reg;
        end
    end

    // cell chain: each cell sees its upper neighbour for shifting removes
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_BITS-1:0] nb_word;
        if (g == DEPTH - 1)
        begin : g_end
            assign nb_word = '0;
        end
        else
        begin : g_mid
            assign nb_word = words[g + 1];
        end
        rdqir_cell #(
            .POS       (g),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .value     (value),
            .last_word (last_word),
            .next_word (nb_word),
            .word      (words[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                limit_reg <= cfg_write_data;
            fill_reg <= fill_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            count_reg  <= fill_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign count     = count_reg;

    // fill never runs past the store
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // reported count is the fill left behind by the item
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == fill_reg))
        else $error("result count differs from fill");

    // a refused append leaves the store alone
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status_next == ST_FULL) |=> (fill_reg == $past(fill_reg)))
        else $error("full append changed fill");

    // a successful take drops exactly one element
    a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_empty && (action == ACT_TAKE_FRONT || action == ACT_TAKE_BACK))
        |=> (fill_reg == $past(fill_reg) - COUNT_W'(1)))
        else $error("take did not decrement fill");

    // no new item while a result is stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !accept)
        else $error("item accepted over a stalled result");

endmodule

// ===== design/rdqir_cell.sv =====
// One storage cell of the deque chain: holds the element at a fixed logical position.
module rdqir_cell #(
    parameter int POS       = 0,
    parameter int WORD_BITS = rdqir_pkg::WORD_BITS
) (
    input  logic                  clk,
    input  rdqir_pkg::cell_cmd_t  cmd,
    input  logic [WORD_BITS-1:0]  value,
    input  logic [WORD_BITS-1:0]  last_word,
    input  logic [WORD_BITS-1:0]  next_word,
    output logic [WORD_BITS-1:0]  word
);
    import rdqir_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 at_pos;
    logic                 in_shift;

    assign at_pos   = (cmd.pos == INDEX_W'(POS));
    // shift window: from the hole up to the element before the back
    assign in_shift = (INDEX_W'(POS) >= cmd.pos) && (COUNT_W'(POS + 1) < cmd.fill);

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.op)
            CELL_APPEND, CELL_WRITE:
            begin
                if (at_pos)
                    word_next = value;
            end
            CELL_SHIFT:
            begin
                if (in_shift)
                    word_next = next_word;
            end
            CELL_FAST:
            begin
                if (at_pos)
                    word_next = last_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
